/* sv/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/gtr_pkg.sv */
`timescale 1ns / 1ps

package gtr_pkg;

    localparam int GLYPH_COUNT = 39;
    localparam int CELL_SIZE   = 8;
    localparam int GLYPH_ROWS  = 6;
    localparam int CELL_BITS   = GLYPH_ROWS * CELL_SIZE;
    localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
    localparam int OFF_W       = 11;   // holds 7 * 255

    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT0 = 6'd26;
    localparam logic [GLYPH_W-1:0] GLYPH_DOT    = 6'd36;
    localparam logic [GLYPH_W-1:0] GLYPH_COLON  = 6'd37;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK  = 6'd38;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    // Configuration register indexes
    localparam logic [2:0] CFG_SCALE    = 3'd0;
    localparam logic [2:0] CFG_FLIP     = 3'd1;
    localparam logic [2:0] CFG_STEP_X   = 3'd2;
    localparam logic [2:0] CFG_STEP_Y   = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_X = 3'd4;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd5;
    localparam logic [2:0] CFG_INK      = 3'd6;

    // Cell rows 1..6, row 1 in the low byte, column c at bit c of its byte.
    localparam logic [CELL_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
        48'h39393F39391E, 48'h1F23231F231F, 48'h1E330303331E,
        48'h1F3F3939391F, 48'h3F03031F033F, 48'h03031F03033F,
        48'h3E333B03331E, 48'h3131313F3131, 48'h1E0C0C0C0C1E,
        48'h0E1B1B18183C, 48'h331B0F0F1B33, 48'h3F0303030303,
        48'h3131353F3B31, 48'h31393D373331, 48'h1E333333331E,
        48'h03031F33331F, 48'h2E132B23231E, 48'h330B1F33331F,
        48'h1E39181E031E, 48'h0C0C0C0C0C3F, 48'h1E3931313131,
        48'h0C1A31313131, 48'h313B3F353131, 48'h21130E0C1A31,
        48'h0C0C0C1E3333, 48'h3F070E1C383F, 48'h1E333333331E,
        48'h1E0C0C0C0E0C, 48'h3F071E38391E, 48'h1F38381E381F,
        48'h183F19191B1E, 48'h1E39381F031F, 48'h1E33331F031E,
        48'h0E0E0C18303F, 48'h1E39391E391E, 48'h1E383E39391E,
        48'h0C0C00000000, 48'h0C0C000C0C00, 48'h000000000000
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADV
    } t_state;

    typedef struct packed {
        logic             lit;
        logic             last;
        logic             done;
        logic [OFF_W-1:0] x_off;
        logic [OFF_W-1:0] y_off;
    } t_scan_stat;

    function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            d = ch - CH_UPPER_A;
            return d[GLYPH_W-1:0];
        end
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d = ch - CH_ZERO;
            return d[GLYPH_W-1:0] + GLYPH_DIGIT0;
        end
        if (ch == CH_PERIOD) return GLYPH_DOT;
        if (ch == CH_COLON) return GLYPH_COLON;
        return GLYPH_BLANK;
    endfunction

endpackage

/* sv/gtr_cell_scan.sv */
`timescale 1ns / 1ps

module gtr_cell_scan
    import gtr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [CELL_BITS-1:0] i_rows,
    input  logic [1:0]           i_flip,
    input  logic [7:0]           i_scale,
    input  logic                 i_step,
    output t_scan_stat           o_stat
);

    logic [CELL_BITS-1:0] r_bits;
    logic [2:0]           r_col;
    logic [2:0]           r_row;
    logic [OFF_W-1:0]     r_xo;
    logic [OFF_W-1:0]     r_yo;

    logic [OFF_W-1:0] s_w;
    logic [OFF_W-1:0] seven_s;
    logic [OFF_W-1:0] six_s;
    logic [OFF_W-1:0] x_start;

    always_comb begin
        s_w     = {3'b000, i_scale};
        seven_s = (s_w << 3) - s_w;
        six_s   = (s_w << 2) + (s_w << 1);
        x_start = i_flip[1] ? seven_s : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_load) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= r_col + 3'd1;
            if (r_col == 3'd7) begin
                r_row <= r_row + 3'd1;
            end
        end
    end

    // Payload side: bit shifter and running offsets
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bits <= i_rows;
            r_xo   <= x_start;
            r_yo   <= i_flip[0] ? six_s : s_w;
        end else if (i_step) begin
            r_bits <= {1'b0, r_bits[CELL_BITS-1:1]};
            if (r_col == 3'd7) begin
                r_xo <= x_start;
                r_yo <= i_flip[0] ? (r_yo - s_w) : (r_yo + s_w);
            end else begin
                r_xo <= i_flip[1] ? (r_xo - s_w) : (r_xo + s_w);
            end
        end
    end

    always_comb begin
        o_stat.lit   = r_bits[0];
        o_stat.last  = (r_bits[CELL_BITS-1:1] == '0);
        o_stat.done  = (r_row == 3'(GLYPH_ROWS - 1)) && (r_col == 3'd7);
        o_stat.x_off = r_xo;
        o_stat.y_off = r_yo;
    end

endmodule

/* sv/glyph_text_renderer_unit.sv */
// Glyph text renderer: turns a stream of character bytes into dot commands.
// Input stream: tdata carries the character code, tuser the first-of-string
// flag, which reloads the cursor from the origin registers before drawing.
// Output stream: one word per lit font pixel, in row then column order; tdata
// packs dot x, dot y, dot size and ink color, tlast marks the final dot of a
// character. Blank characters give no words but still advance the cursor.
// Timing: a character is taken in the idle state, then its six 8-bit glyph
// rows are shifted out of the cell scanner one bit per cycle unless a lit bit
// stalls, then the ADV state adds the cursor advance. The earliest dot is
// registered in the scanner on acceptance and then in the output register.
// The bit scan sets the rate; no new character is taken until ADV is done.
// Stall: the scanner holds on a lit bit while the output register is full
// and not taken, so every dot is delivered exactly once.
// Configuration is to be written via the write port while idle (unenforced).
// Reset (synchronous, active low) clears the cursor, empties the output
// register and restores the register defaults (scale 1, step x 1, white ink).
`timescale 1ns / 1ps

module glyph_text_renderer_unit
    import gtr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    // Character input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tuser,   // [0] first
    // Dot output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [15:0] dot_x, [31:16] dot_y,
                                     // [39:32] dot_size, [63:40] dot_color
    output logic        o_m_tlast    // last dot of the character
);

    t_state r_state, n_state;

    // Configuration registers
    logic [7:0]  r_scale;
    logic [1:0]  r_flip;
    logic [7:0]  r_step_x;
    logic [7:0]  r_step_y;
    logic [15:0] r_org_x;
    logic [15:0] r_org_y;
    logic [23:0] r_ink;

    logic [15:0] r_cur_x;
    logic [15:0] r_cur_y;

    logic        r_ovalid;
    logic [63:0] r_odata;
    logic        r_olast;

    logic        accept;
    logic        slot_free;
    logic        scan_step;
    logic        emit;
    logic [7:0]  s_eff;
    t_scan_stat  stat;

    logic signed [16:0] prod_x;
    logic signed [16:0] prod_y;
    logic [15:0]        adv_x;
    logic [15:0]        adv_y;

    assign s_eff     = (r_scale == 8'd0) ? 8'd1 : r_scale;
    assign accept    = i_s_tvalid && o_s_tready;
    assign slot_free = !r_ovalid || i_m_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) begin
                n_state = ST_SCAN;
            end
            ST_SCAN: if (scan_step && stat.done) begin
                n_state = ST_ADV;
            end
            ST_ADV: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: advance the scanner on a dark bit, or on a lit bit once
    // the output register has room.
    always_comb begin
        o_s_tready = 1'b0;
        scan_step  = 1'b0;
        emit       = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_SCAN: begin
                scan_step = !stat.lit || slot_free;
                emit      = stat.lit && slot_free;
            end
            ST_ADV: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 8'd1;
            r_flip   <= 2'd0;
            r_step_x <= 8'd1;
            r_step_y <= 8'd0;
            r_org_x  <= 16'd0;
            r_org_y  <= 16'd0;
            r_ink    <= 24'hFFFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE:    r_scale  <= i_cfg_data[7:0];
                CFG_FLIP:     r_flip   <= i_cfg_data[1:0];
                CFG_STEP_X:   r_step_x <= i_cfg_data[7:0];
                CFG_STEP_Y:   r_step_y <= i_cfg_data[7:0];
                CFG_ORIGIN_X: r_org_x  <= i_cfg_data[15:0];
                CFG_ORIGIN_Y: r_org_y  <= i_cfg_data[15:0];
                CFG_INK:      r_ink    <= i_cfg_data;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Cursor advance: scale * step cells, eight pixels a cell, mod 2^16
    always_comb begin
        prod_x = $signed({9'd0, s_eff}) * $signed({{9{r_step_x[7]}}, r_step_x});
        prod_y = $signed({9'd0, s_eff}) * $signed({{9{r_step_y[7]}}, r_step_y});
        adv_x  = {prod_x[12:0], 3'b000};
        adv_y  = {prod_y[12:0], 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= 16'd0;
            r_cur_y <= 16'd0;
        end else if (accept && i_s_tuser) begin
            r_cur_x <= r_org_x;
            r_cur_y <= r_org_y;
        end else if (r_state == ST_ADV) begin
            r_cur_x <= r_cur_x + adv_x;
            r_cur_y <= r_cur_y + adv_y;
        end
    end

    gtr_cell_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_rows  (FONT_ROM[glyph_index(i_s_tdata)]),
        .i_flip  (r_flip),
        .i_scale (s_eff),
        .i_step  (scan_step),
        .o_stat  (stat)
    );

    // Output register: fill on emit, empty when the receiver takes the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_odata <= {r_ink, s_eff,
                        r_cur_y + {5'd0, stat.y_off},
                        r_cur_x + {5'd0, stat.x_off}};
            r_olast <= stat.last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule

/* sv/gtr_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tlast
);

    // a stalled output word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // one character at a time: ready drops right after a character is taken
    `ASSERT_NEXT(a_one_char, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // dots always have a nonzero size
    `ASSERT_SAME(a_size_nz, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[39:32] != 8'd0)

endmodule

bind glyph_text_renderer_unit gtr_checker u_gtr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
